/* hw/rtl/ddqi_pkg.sv */
// shared types and constants for the descriptor deque with insert
package ddqi_pkg;

  localparam int unsigned CAPACITY_DEF  = 64;
  localparam int unsigned ADDR_BITS_DEF = 32;
  localparam int unsigned LEN_BITS_DEF  = 16;

  // fixed port field widths
  localparam int unsigned ACTION_W = 3;
  localparam int unsigned IN_ADDR_W = 32;
  localparam int unsigned IN_LEN_W = 16;
  localparam int unsigned POS_W = 7;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned OUT_ADDR_W = 32;
  localparam int unsigned OUT_LEN_W = 16;
  localparam int unsigned COUNT_W = 7;
  localparam int unsigned TOTAL_W = 22;

  typedef enum logic [ACTION_W-1:0] {
    ACT_PUSH_HEAD = 3'd0,
    ACT_PUSH_TAIL = 3'd1,
    ACT_POP_HEAD  = 3'd2,
    ACT_POP_TAIL  = 3'd3,
    ACT_INSERT    = 3'd4
  } act_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK       = 2'd0,
    ST_OVERFLOW = 2'd1,
    ST_EMPTY    = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_SHIFT,
    S_FIN
  } state_e;

  // controller to datapath
  typedef struct packed {
    logic load;
    logic shift_start;
    logic shift_step;
    logic commit;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic needs_shift;
    logic shift_last;
    logic out_free;
  } sts_t;

endpackage

/* hw/rtl/ddqi_ram.sv */
// generic single write port ram with registered read
module ddqi_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* hw/rtl/ddqi_ctrl.sv */
// control state machine for the descriptor deque
module ddqi_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  ddqi_pkg::sts_t  sts_i,
  output ddqi_pkg::cmd_t  cmd_o
);

  ddqi_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ddqi_pkg::S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      ddqi_pkg::S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = ddqi_pkg::S_EXEC;
        end
      end
      ddqi_pkg::S_EXEC: begin
        if (sts_i.needs_shift) begin
          cmd_o.shift_start = 1'b1;
          state_d           = ddqi_pkg::S_SHIFT;
        end else if (sts_i.out_free) begin
          cmd_o.commit = 1'b1;
          state_d      = ddqi_pkg::S_IDLE;
        end
      end
      ddqi_pkg::S_SHIFT: begin
        cmd_o.shift_step = 1'b1;
        if (sts_i.shift_last) begin
          state_d = ddqi_pkg::S_FIN;
        end
      end
      ddqi_pkg::S_FIN: begin
        if (sts_i.out_free) begin
          cmd_o.commit = 1'b1;
          state_d      = ddqi_pkg::S_IDLE;
        end
      end
      default: begin
        state_d = ddqi_pkg::S_IDLE;
      end
    endcase
  end

endmodule

/* hw/rtl/ddqi_dp.sv */
// datapath: window registers, descriptor store, shift pointer and result register
module ddqi_dp #(
  parameter int unsigned CAPACITY  = ddqi_pkg::CAPACITY_DEF,
  parameter int unsigned ADDR_BITS = ddqi_pkg::ADDR_BITS_DEF,
  parameter int unsigned LEN_BITS  = ddqi_pkg::LEN_BITS_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  ddqi_pkg::cmd_t                    cmd_i,
  output ddqi_pkg::sts_t                    sts_o,
  input  logic [ddqi_pkg::ACTION_W-1:0]     action_i,
  input  logic [ddqi_pkg::IN_ADDR_W-1:0]    buf_addr_i,
  input  logic [ddqi_pkg::IN_LEN_W-1:0]     buf_len_i,
  input  logic [ddqi_pkg::POS_W-1:0]        position_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic [ddqi_pkg::STATUS_W-1:0]     status_o,
  output logic [ddqi_pkg::OUT_ADDR_W-1:0]   out_addr_o,
  output logic [ddqi_pkg::OUT_LEN_W-1:0]    out_len_o,
  output logic [ddqi_pkg::COUNT_W-1:0]      entry_count_o,
  output logic [ddqi_pkg::TOTAL_W-1:0]      total_bytes_o
);

  localparam int unsigned IDX_W = $clog2(CAPACITY);
  localparam int unsigned CNT_W = $clog2(CAPACITY + 1);
  localparam int unsigned SUM_W = CNT_W + 1;
  localparam int unsigned PW    = (CNT_W > ddqi_pkg::POS_W) ? CNT_W : ddqi_pkg::POS_W;
  localparam int unsigned ENT_W = ADDR_BITS + LEN_BITS;
  localparam int unsigned TOT_W = ddqi_pkg::TOTAL_W;

  // window and totals
  logic [CNT_W-1:0] ws_q, ws_d;
  logic [CNT_W-1:0] held_q, held_d;
  logic [TOT_W-1:0] tot_q, tot_d;

  // latched item
  ddqi_pkg::act_e              action_q;
  logic [ADDR_BITS-1:0]        addr_q;
  logic [LEN_BITS-1:0]         len_q;
  logic [ddqi_pkg::POS_W-1:0]  pos_q;
  logic [IDX_W-1:0]            ptr_q;

  // result register
  logic                             out_valid_q;
  logic [ddqi_pkg::STATUS_W-1:0]    status_q;
  logic [ddqi_pkg::OUT_ADDR_W-1:0]  oaddr_q;
  logic [ddqi_pkg::OUT_LEN_W-1:0]   olen_q;
  logic [ddqi_pkg::COUNT_W-1:0]     ocount_q;
  logic [TOT_W-1:0]                 ototal_q;

  // ram ports
  logic             ram_we, ram_re;
  logic [IDX_W-1:0] ram_waddr, ram_raddr;
  logic [ENT_W-1:0] ram_wdata, ram_rdata;
  logic [ADDR_BITS-1:0] rd_addr;
  logic [LEN_BITS-1:0]  rd_len;

  // derived window positions
  logic [SUM_W-1:0] end_sum;
  logic             full;
  logic             pos_lt;
  logic [CNT_W-1:0] ins_off;
  logic [IDX_W-1:0] ins_idx, tail_idx, last_idx, head_idx;
  logic             shift_last;

  // commit decode
  ddqi_pkg::status_e st_c;
  logic              we_c;
  logic [IDX_W-1:0]  waddr_c;
  logic              pop_ok;

  assign end_sum  = SUM_W'(ws_q) + SUM_W'(held_q);
  assign full     = end_sum >= SUM_W'(CAPACITY);
  assign pos_lt   = PW'(pos_q) < PW'(held_q);
  assign ins_off  = pos_lt ? CNT_W'(pos_q) : held_q;
  assign ins_idx  = IDX_W'(SUM_W'(ws_q) + SUM_W'(ins_off));
  assign tail_idx = IDX_W'(end_sum);
  assign last_idx = IDX_W'(end_sum - SUM_W'(1));
  assign head_idx = IDX_W'(ws_q);
  assign shift_last = ptr_q == ins_idx;

  assign rd_addr = ram_rdata[ENT_W-1:LEN_BITS];
  assign rd_len  = ram_rdata[LEN_BITS-1:0];

  assign sts_o.needs_shift = (action_q == ddqi_pkg::ACT_INSERT) && !full && pos_lt;
  assign sts_o.shift_last  = shift_last;
  assign sts_o.out_free    = !out_valid_q || out_ready_i;

  always_comb begin
    st_c    = ddqi_pkg::ST_OK;
    we_c    = 1'b0;
    waddr_c = tail_idx;
    pop_ok  = 1'b0;
    ws_d    = ws_q;
    held_d  = held_q;
    tot_d   = tot_q;
    case (action_q)
      ddqi_pkg::ACT_PUSH_HEAD: begin
        if (ws_q == '0) begin
          st_c = ddqi_pkg::ST_OVERFLOW;
        end else begin
          we_c    = 1'b1;
          waddr_c = IDX_W'(ws_q - CNT_W'(1));
          ws_d    = ws_q - CNT_W'(1);
          held_d  = held_q + CNT_W'(1);
          tot_d   = tot_q + TOT_W'(len_q);
        end
      end
      ddqi_pkg::ACT_PUSH_TAIL: begin
        if (full) begin
          st_c = ddqi_pkg::ST_OVERFLOW;
        end else begin
          we_c   = 1'b1;
          held_d = held_q + CNT_W'(1);
          tot_d  = tot_q + TOT_W'(len_q);
        end
      end
      ddqi_pkg::ACT_POP_HEAD, ddqi_pkg::ACT_POP_TAIL: begin
        if (held_q == '0) begin
          st_c = ddqi_pkg::ST_EMPTY;
        end else begin
          pop_ok = 1'b1;
          if (action_q == ddqi_pkg::ACT_POP_HEAD) begin
            ws_d = ws_q + CNT_W'(1);
          end
          held_d = held_q - CNT_W'(1);
          tot_d  = tot_q - TOT_W'(rd_len);
        end
      end
      ddqi_pkg::ACT_INSERT: begin
        if (full) begin
          st_c = ddqi_pkg::ST_OVERFLOW;
        end else begin
          // later entries were already moved up, position beyond count appends
          we_c    = 1'b1;
          waddr_c = ins_idx;
          held_d  = held_q + CNT_W'(1);
          tot_d   = tot_q + TOT_W'(len_q);
        end
      end
      default: begin
      end
    endcase
  end

  // ram port muxing
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = waddr_c;
    ram_wdata = {addr_q, len_q};
    if (cmd_i.shift_step) begin
      ram_we    = 1'b1;
      ram_waddr = IDX_W'(ptr_q + IDX_W'(1));
      ram_wdata = ram_rdata;
    end else if (cmd_i.commit) begin
      ram_we = we_c;
    end

    ram_re    = 1'b0;
    ram_raddr = last_idx;
    if (cmd_i.load) begin
      ram_re = 1'b1;
      ram_raddr = (action_i == ddqi_pkg::ACT_POP_HEAD) ? head_idx : last_idx;
    end else if (cmd_i.shift_start) begin
      ram_re = 1'b1;
    end else if (cmd_i.shift_step) begin
      ram_re    = !shift_last;
      ram_raddr = ptr_q - IDX_W'(1);
    end
  end

  ddqi_ram #(
    .WIDTH (ENT_W),
    .DEPTH (CAPACITY)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ws_q        <= CNT_W'(CAPACITY / 3);
      held_q      <= '0;
      tot_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.commit) begin
        ws_q        <= ws_d;
        held_q      <= held_d;
        tot_q       <= tot_d;
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      action_q <= ddqi_pkg::act_e'(action_i);
      addr_q   <= ADDR_BITS'(buf_addr_i);
      len_q    <= LEN_BITS'(buf_len_i);
      pos_q    <= position_i;
    end
    if (cmd_i.shift_start) begin
      ptr_q <= last_idx;
    end else if (cmd_i.shift_step) begin
      ptr_q <= ptr_q - IDX_W'(1);
    end
    if (cmd_i.commit) begin
      status_q <= st_c;
      oaddr_q  <= pop_ok ? ddqi_pkg::OUT_ADDR_W'(rd_addr) : '0;
      olen_q   <= pop_ok ? ddqi_pkg::OUT_LEN_W'(rd_len) : '0;
      ocount_q <= ddqi_pkg::COUNT_W'(held_d);
      ototal_q <= tot_d;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign status_o      = status_q;
  assign out_addr_o    = oaddr_q;
  assign out_len_o     = olen_q;
  assign entry_count_o = ocount_q;
  assign total_bytes_o = ototal_q;

  // window never runs past the end of the store
  a_window_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    end_sum <= SUM_W'(CAPACITY))
    else $error("window runs past store end");

  // a new result never overwrites one that has not been taken
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.commit |-> (!out_valid_q || out_ready_i))
    else $error("result register overwritten");

  // shifting happens only for an insert and stays at or above the insert slot
  a_shift_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.shift_step |-> (action_q == ddqi_pkg::ACT_INSERT) && (ptr_q >= ins_idx))
    else $error("shift outside insert range");

  // window state changes only when an item completes
  a_state_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !cmd_i.commit |=> $stable(held_q) && $stable(ws_q) && $stable(tot_q))
    else $error("window state changed without commit");

endmodule

/* hw/rtl/descriptor_deque_with_insert_unit.sv */
// Push, pop and ignored actions go from acceptance through the EXEC state, which registers
// the result once the result register is free.
// An insert inside the window goes from EXEC through SHIFT, one store read and write per
// moved entry, and then FIN, which registers the result once the result register is free.
// One item is in work at a time; the next is taken once the result is registered.
// Reset (rst_ni, async, active low) empties the window and sets its start to CAPACITY/3.
module descriptor_deque_with_insert_unit #(
  parameter int unsigned CAPACITY  = ddqi_pkg::CAPACITY_DEF,
  parameter int unsigned ADDR_BITS = ddqi_pkg::ADDR_BITS_DEF,
  parameter int unsigned LEN_BITS  = ddqi_pkg::LEN_BITS_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic [ddqi_pkg::ACTION_W-1:0]   action_i,
  input  logic [ddqi_pkg::IN_ADDR_W-1:0]  buf_addr_i,
  input  logic [ddqi_pkg::IN_LEN_W-1:0]   buf_len_i,
  input  logic [ddqi_pkg::POS_W-1:0]      position_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic [ddqi_pkg::STATUS_W-1:0]   status_o,
  output logic [ddqi_pkg::OUT_ADDR_W-1:0] out_addr_o,
  output logic [ddqi_pkg::OUT_LEN_W-1:0]  out_len_o,
  output logic [ddqi_pkg::COUNT_W-1:0]    entry_count_o,
  output logic [ddqi_pkg::TOTAL_W-1:0]    total_bytes_o
);

  ddqi_pkg::cmd_t cmd;
  ddqi_pkg::sts_t sts;

  ddqi_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  ddqi_dp #(
    .CAPACITY  (CAPACITY),
    .ADDR_BITS (ADDR_BITS),
    .LEN_BITS  (LEN_BITS)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .action_i      (action_i),
    .buf_addr_i    (buf_addr_i),
    .buf_len_i     (buf_len_i),
    .position_i    (position_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .status_o      (status_o),
    .out_addr_o    (out_addr_o),
    .out_len_o     (out_len_o),
    .entry_count_o (entry_count_o),
    .total_bytes_o (total_bytes_o)
  );

endmodule

/* dv/descriptor_deque_with_insert_unit_tb.sv */
// testbench for the descriptor deque with insert: directed and random action streams checked against a predictor
`timescale 1ns / 100ps

module descriptor_deque_with_insert_unit_tb;
  import ddqi_pkg::*;

  localparam int unsigned CAPACITY       = CAPACITY_DEF;
  localparam int unsigned RANDOM_OPS     = 1200;
  localparam int unsigned WATCHDOG_LIMIT = 4000;
  localparam int unsigned SETTLE_CYCLES  = 100;

  // codes above the insert action are ignored by the block
  localparam logic [ACTION_W-1:0] ACT_RSVD_FIRST = 3'd5;
  localparam logic [ACTION_W-1:0] ACT_RSVD_LAST  = 3'd7;

  localparam int MODE_MIX    = 0;
  localparam int MODE_FILL   = 1;
  localparam int MODE_DRAIN  = 2;
  localparam int MODE_INSERT = 3;

  typedef struct {
    logic [ACTION_W-1:0]  action;
    logic [IN_ADDR_W-1:0] addr;
    logic [IN_LEN_W-1:0]  len;
    logic [POS_W-1:0]     pos;
    bit                   wait_drain;
    int unsigned          idle_pct;
    int unsigned          stall_pct;
  } op_t;

  typedef struct {
    logic [STATUS_W-1:0]   status;
    logic [OUT_ADDR_W-1:0] addr;
    logic [OUT_LEN_W-1:0]  len;
    logic [COUNT_W-1:0]    count;
    logic [TOTAL_W-1:0]    total;
  } reply_t;

  logic                  clk_i       = 1'b0;
  logic                  rst_ni      = 1'b0;
  logic                  in_valid_i  = 1'b0;
  logic                  in_ready_o;
  logic [ACTION_W-1:0]   action_i    = '0;
  logic [IN_ADDR_W-1:0]  buf_addr_i  = '0;
  logic [IN_LEN_W-1:0]   buf_len_i   = '0;
  logic [POS_W-1:0]      position_i  = '0;
  logic                  out_valid_o;
  logic                  out_ready_i = 1'b0;
  logic [STATUS_W-1:0]   status_o;
  logic [OUT_ADDR_W-1:0] out_addr_o;
  logic [OUT_LEN_W-1:0]  out_len_o;
  logic [COUNT_W-1:0]    entry_count_o;
  logic [TOTAL_W-1:0]    total_bytes_o;

  descriptor_deque_with_insert_unit dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .action_i      (action_i),
    .buf_addr_i    (buf_addr_i),
    .buf_len_i     (buf_len_i),
    .position_i    (position_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .status_o      (status_o),
    .out_addr_o    (out_addr_o),
    .out_len_o     (out_len_o),
    .entry_count_o (entry_count_o),
    .total_bytes_o (total_bytes_o)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  op_t         queued_ops[$];
  reply_t      predicted_replies[$];
  int unsigned mismatches   = 0;
  int unsigned quiet_cycles = 0;
  int unsigned stall_pct    = 0;
  bit          op_taken     = 1'b0;

  // predictor copy of the store
  logic [IN_ADDR_W-1:0] slot_addr_q[CAPACITY];
  logic [IN_LEN_W-1:0]  slot_len_q[CAPACITY];
  int unsigned          win_lo     = CAPACITY / 3;
  int unsigned          held       = 0;
  int unsigned          bytes_held = 0;

  // put a descriptor at window index k, moving later entries up one slot
  function automatic void place_entry(int unsigned k, logic [IN_ADDR_W-1:0] addr,
                                      logic [IN_LEN_W-1:0] len);
    for (int unsigned i = win_lo + held; i > win_lo + k; i--) begin
      slot_addr_q[i] = slot_addr_q[i-1];
      slot_len_q[i]  = slot_len_q[i-1];
    end
    slot_addr_q[win_lo+k] = addr;
    slot_len_q[win_lo+k]  = len;
    held++;
    bytes_held += len;
  endfunction

  function automatic reply_t apply_deque_op(op_t op);
    reply_t      r;
    int unsigned idx;
    r.status = ST_OK;
    r.addr   = '0;
    r.len    = '0;
    case (op.action)
      ACT_PUSH_HEAD: begin
        if (win_lo == 0) begin
          r.status = ST_OVERFLOW;
        end else begin
          // window grows down, held entries stay where they are
          win_lo--;
          slot_addr_q[win_lo] = op.addr;
          slot_len_q[win_lo]  = op.len;
          held++;
          bytes_held += op.len;
        end
      end
      ACT_PUSH_TAIL: begin
        if (win_lo + held >= CAPACITY) r.status = ST_OVERFLOW;
        else place_entry(held, op.addr, op.len);
      end
      ACT_POP_HEAD, ACT_POP_TAIL: begin
        if (held == 0) begin
          r.status = ST_EMPTY;
        end else begin
          idx = (op.action == ACT_POP_HEAD) ? win_lo : win_lo + held - 1;
          r.addr = slot_addr_q[idx];
          r.len  = slot_len_q[idx];
          if (op.action == ACT_POP_HEAD) win_lo++;
          held--;
          bytes_held -= r.len;
        end
      end
      ACT_INSERT: begin
        // a position past the count appends like a tail push
        if (win_lo + held >= CAPACITY) r.status = ST_OVERFLOW;
        else if (op.pos > held) place_entry(held, op.addr, op.len);
        else place_entry(op.pos, op.addr, op.len);
      end
      default: ;
    endcase
    r.count = held[COUNT_W-1:0];
    r.total = bytes_held[TOTAL_W-1:0];
    return r;
  endfunction

  task automatic check_field(input string what, input logic [31:0] want, got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0h actual %0h", $time, what, want, got);
      mismatches++;
    end
  endtask

  // monitor: predicts on input items, checks result items, runs the watchdog
  always @(posedge clk_i) begin
    op_t    seen;
    reply_t want;
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        if (predicted_replies.size() == 0) begin
          $display("%0t: result item with none expected, status %0h count %0h", $time,
                   status_o, entry_count_o);
          mismatches++;
        end else begin
          want = predicted_replies.pop_front();
          check_field("status", want.status, status_o);
          check_field("out_addr", want.addr, out_addr_o);
          check_field("out_len", want.len, out_len_o);
          check_field("entry_count", want.count, entry_count_o);
          check_field("total_bytes", want.total, total_bytes_o);
        end
      end
      if (in_valid_i && in_ready_o) begin
        seen.action = action_i;
        seen.addr   = buf_addr_i;
        seen.len    = buf_len_i;
        seen.pos    = position_i;
        predicted_replies.push_back(apply_deque_op(seen));
        op_taken = 1'b1;
      end
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("%0t: no handshake for %0d cycles", $time, quiet_cycles);
        $display("descriptor_deque_with_insert_unit_tb failed");
        $finish;
      end
    end
  end

  // driver: presents queued items and the result-side ready
  always @(negedge clk_i) begin
    op_t nxt;
    bit  launch;
    if (rst_ni) begin
      launch = 1'b0;
      if (!in_valid_i || op_taken) begin
        if (queued_ops.size() > 0) begin
          if (queued_ops[0].wait_drain) begin
            if (predicted_replies.size() == 0) void'(queued_ops.pop_front());
          end else if ($urandom_range(99) >= queued_ops[0].idle_pct) begin
            nxt = queued_ops.pop_front();
            launch = 1'b1;
            stall_pct = nxt.stall_pct;
            action_i   <= nxt.action;
            buf_addr_i <= nxt.addr;
            buf_len_i  <= nxt.len;
            position_i <= nxt.pos;
          end
        end
        in_valid_i <= launch;
      end
      op_taken = 1'b0;
      out_ready_i <= ($urandom_range(99) >= stall_pct);
    end
  end

  int unsigned cur_idle  = 0;
  int unsigned cur_stall = 0;

  task automatic add_op(input logic [ACTION_W-1:0] action, input logic [IN_ADDR_W-1:0] addr,
                        input logic [IN_LEN_W-1:0] len, input logic [POS_W-1:0] pos);
    op_t op;
    op.action     = action;
    op.addr       = addr;
    op.len        = len;
    op.pos        = pos;
    op.wait_drain = 1'b0;
    op.idle_pct   = cur_idle;
    op.stall_pct  = cur_stall;
    queued_ops.push_back(op);
  endtask

  task automatic add_drain_point();
    op_t op;
    op = '{action: '0, addr: '0, len: '0, pos: '0, wait_drain: 1'b1,
           idle_pct: 0, stall_pct: 0};
    queued_ops.push_back(op);
  endtask

  function automatic logic [ACTION_W-1:0] pick_action(int mode, int unsigned k);
    int unsigned r;
    r = $urandom_range(19);
    case (mode)
      MODE_FILL: begin
        // head pushes then tail pushes, running into overflow on both ends
        if (k < 26) return ACT_PUSH_HEAD;
        if (k < 72) return (r < 3) ? ACT_INSERT : ACT_PUSH_TAIL;
        return ACT_INSERT;
      end
      MODE_DRAIN: begin
        if (r < 2) return ACT_PUSH_TAIL;
        return (r < 11) ? ACT_POP_HEAD : ACT_POP_TAIL;
      end
      MODE_INSERT: begin
        if (r < 12) return ACT_INSERT;
        if (r < 16) return ACT_PUSH_TAIL;
        return (r < 18) ? ACT_POP_HEAD : ACT_POP_TAIL;
      end
      default: begin
        if (r == 0) return ACTION_W'($urandom_range(ACT_RSVD_LAST, ACT_RSVD_FIRST));
        return ACTION_W'($urandom_range(ACT_INSERT, ACT_PUSH_HEAD));
      end
    endcase
  endfunction

  initial begin
    int unsigned real_ops;
    int unsigned seg;
    int unsigned seg_len;
    int unsigned r;
    int          mode;
    logic [ACTION_W-1:0] act;
    logic [IN_LEN_W-1:0] len;
    logic [POS_W-1:0]    pos;

    // empty pops, ignored codes, every insert position case, all-ones and all-zeros fields
    add_op(ACT_POP_HEAD, '1, '1, '1);
    add_op(ACT_POP_TAIL, '0, '0, '0);
    add_op(ACT_RSVD_FIRST, '1, '1, '1);
    add_op(ACT_RSVD_LAST, 32'h1234_5678, 16'h9abc, 7'h2a);
    add_op(ACT_INSERT, 32'h0000_1000, 16'h0040, 7'd0);
    add_op(ACT_PUSH_HEAD, '1, '1, '0);
    add_op(ACT_PUSH_TAIL, '0, '0, '1);
    add_op(ACT_INSERT, 32'h8000_0001, 16'h8001, 7'd127);
    add_op(ACT_INSERT, 32'haaaa_aaaa, 16'h5555, 7'd1);
    add_op(ACT_INSERT, 32'h5555_5555, 16'haaaa, 7'd5);
    add_op(ACT_INSERT, 32'h0f0f_f0f0, 16'h00ff, 7'd2);
    add_op(ACT_RSVD_FIRST + 3'd1, '0, '0, '0);
    add_op(ACT_POP_HEAD, '0, '0, '0);
    add_op(ACT_POP_TAIL, '0, '0, '0);
    add_op(ACT_POP_HEAD, '0, '0, '0);
    add_op(ACT_POP_TAIL, '0, '0, '0);
    add_op(ACT_POP_TAIL, '0, '0, '0);
    add_op(ACT_POP_HEAD, '0, '0, '0);
    add_op(ACT_POP_TAIL, '0, '0, '0);
    add_drain_point();

    real_ops = 0;
    seg = 0;
    while (real_ops < RANDOM_OPS) begin
      case (seg % 5)
        1: begin cur_idle = 75; cur_stall = 0;  end
        2: begin cur_idle = 0;  cur_stall = 75; end
        3: begin cur_idle = 22; cur_stall = 22; end
        default: begin cur_idle = 0; cur_stall = 0; end
      endcase
      mode = $urandom_range(MODE_INSERT, MODE_MIX);
      seg_len = (mode == MODE_FILL) ? 80 : $urandom_range(60, 20);
      for (int unsigned k = 0; k < seg_len; k++) begin
        act = pick_action(mode, k);
        r = $urandom_range(9);
        len = (r == 0) ? '0 : (r < 3) ? '1 : IN_LEN_W'($urandom());
        r = $urandom_range(9);
        pos = (r < 6) ? POS_W'($urandom_range(24)) :
              (r < 8) ? POS_W'($urandom_range(127)) : '1;
        add_op(act, $urandom(), len, pos);
        if (act <= ACT_INSERT) real_ops++;
      end
      if (seg % 3 == 2) add_drain_point();
      seg++;
    end

    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    while (queued_ops.size() != 0 || predicted_replies.size() != 0 || in_valid_i)
      @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);

    if (mismatches == 0) begin
      $display("descriptor_deque_with_insert_unit_tb passed");
    end else begin
      $display("descriptor_deque_with_insert_unit_tb failed");
    end
    $finish;
  end

endmodule
